// File: hw/rtl/sfb_pkg.sv
// Package for the sensor frame builder: frame constants, byte positions,
// register indexes and the CRC-8 byte step. No dependencies.
package sfb_pkg;

	localparam int SFB_SAMPLE_BITS = 10;
	localparam int FRAME_LEN       = 14;
	localparam int IDX_W           = 4;
	localparam int CODE_W          = 5;
	localparam int CODE_LEVELS     = 31;

	// code >= k exactly when sample * (2k - 1) <= BATT_LIMIT
	localparam int BATT_LIMIT = 10240;

	localparam logic [7:0] FAMILY_CODE = 8'h51;
	localparam logic [7:0] CRC_POLY    = 8'h31;
	localparam logic [7:0] FIXED_7F    = 8'h7F;
	localparam logic [7:0] FIXED_F8    = 8'hF8;
	localparam logic [7:0] FIXED_FF    = 8'hFF;
	localparam logic [8:0] AD_BASE     = 9'd56;

	localparam logic [IDX_W-1:0] POS_FAMILY = 4'd0;
	localparam logic [IDX_W-1:0] POS_ID_HI  = 4'd1;
	localparam logic [IDX_W-1:0] POS_ID_MID = 4'd2;
	localparam logic [IDX_W-1:0] POS_ID_LO  = 4'd3;
	localparam logic [IDX_W-1:0] POS_BATT   = 4'd4;
	localparam logic [IDX_W-1:0] POS_7F     = 4'd5;
	localparam logic [IDX_W-1:0] POS_MOIST  = 4'd6;
	localparam logic [IDX_W-1:0] POS_AD_HI  = 4'd7;
	localparam logic [IDX_W-1:0] POS_AD_LO  = 4'd8;
	localparam logic [IDX_W-1:0] POS_CRC    = 4'd12;
	localparam logic [IDX_W-1:0] POS_SUM    = 4'd13;

	localparam logic REG_DEVICE_ID = 1'b0;
	localparam logic REG_BOOST     = 1'b1;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// File: hw/rtl/sensor_frame_builder_unit.sv
// Sensor frame builder: battery code pipeline and 14-byte frame serializer.
// Depends on sfb_pkg.
//
// Each accepted beat (switch state, supply sample) produces one 14-byte frame,
// one byte per output beat, tlast on the checksum byte. The serializer takes a
// new frame only once the last byte of the current one is accepted, as the
// output port carries one frame byte per beat. Three pipeline stages (sample
// register, 31 parallel threshold compares, thermometer encode) sit ahead of
// the serializer and keep taking beats while a frame is still being sent,
// until all three hold a beat. CRC-8 and byte sum are accumulated as bytes
// leave. Configuration writes are accepted in any cycle.
module sensor_frame_builder_unit
	import sfb_pkg::*;
#(
	parameter int SAMPLE_BITS = SFB_SAMPLE_BITS,
	localparam int IN_W = ((2 + SAMPLE_BITS + 7) / 8) * 8,
	localparam int PROD_W = SAMPLE_BITS + 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,   // reed_state, battery_sample, zero pad
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // frame_byte, byte_index, zero pad
	output logic             m_axis_tlast,   // last_byte
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [23:0]      cfg_data
);

	logic [23:0] device_id_q;
	logic [2:0]  boost_q;

	logic                   v_s1, v_s2, v_s3;
	logic [1:0]             reed_s1, reed_s2, reed_s3;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [CODE_LEVELS-1:0] therm_s2;
	logic [CODE_W-1:0]      code_s3;

	logic                   busy_q;
	logic [IDX_W-1:0]       cnt_q;
	logic [1:0]             reed_q;
	logic [CODE_W-1:0]      code_q;
	logic [7:0]             crc_q;
	logic [7:0]             sum_q;

	logic                   rdy1, rdy2, rdy3, ser_free, last_c;
	logic [CODE_LEVELS-1:0] therm_c;
	logic [CODE_W-1:0]      code_c;
	logic [7:0]             byte_c;
	logic [8:0]             ad_c;
	logic [7:0]             moist_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q <= '0;
			boost_q     <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEVICE_ID: device_id_q <= cfg_data;
				REG_BOOST:     boost_q     <= cfg_data[2:0];
				default:       ;
			endcase
		end
	end

	assign last_c   = (cnt_q == POS_SUM);
	assign ser_free = !busy_q || (m_axis_tready && last_c);
	assign rdy3     = !v_s3 || ser_free;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_axis_tready = rdy1;

	// threshold compares, one per code level
	always_comb begin
		for (int k = 0; k < CODE_LEVELS; k++) begin
			therm_c[k] = (PROD_W'(sample_s1) * PROD_W'(2 * k + 1)) <= PROD_W'(BATT_LIMIT);
		end
	end

	// thermometer to binary: bit j is the parity of taps m*2^j-1
	always_comb begin
		code_c = '0;
		for (int j = 0; j < CODE_W; j++) begin
			for (int m = 1; m <= CODE_LEVELS; m++) begin
				if (m * (1 << j) - 1 < CODE_LEVELS) begin
					code_c[j] = code_c[j] ^ therm_s2[m * (1 << j) - 1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_axis_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && s_axis_tvalid) begin
			reed_s1   <= s_axis_tdata[1:0];
			sample_s1 <= s_axis_tdata[SAMPLE_BITS+1:2];
		end
		if (rdy2 && v_s1) begin
			reed_s2  <= reed_s1;
			therm_s2 <= therm_c;
		end
		if (rdy3 && v_s2) begin
			reed_s3 <= reed_s2;
			code_s3 <= code_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ser_free) begin
			busy_q <= v_s3;
			cnt_q  <= '0;
		end else if (m_axis_tready) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ser_free) begin
			if (v_s3) begin
				reed_q <= reed_s3;
				code_q <= code_s3;
			end
			crc_q <= '0;
			sum_q <= '0;
		end else if (m_axis_tready) begin
			crc_q <= crc8_step(crc_q, byte_c);
			sum_q <= sum_q + byte_c;
		end
	end

	// state * 10 as 8x + 2x
	assign moist_c = {3'b000, reed_q, 3'b000} + {5'b00000, reed_q, 1'b0};
	assign ad_c    = AD_BASE + {1'b0, moist_c};

	always_comb begin
		case (cnt_q)
			POS_FAMILY: byte_c = FAMILY_CODE;
			POS_ID_HI:  byte_c = device_id_q[23:16];
			POS_ID_MID: byte_c = device_id_q[15:8];
			POS_ID_LO:  byte_c = device_id_q[7:0];
			POS_BATT:   byte_c = {boost_q, code_q};
			POS_7F:     byte_c = FIXED_7F;
			POS_MOIST:  byte_c = moist_c;
			POS_AD_HI:  byte_c = FIXED_F8 | {7'b0000000, ad_c[8]};
			POS_AD_LO:  byte_c = ad_c[7:0];
			POS_CRC:    byte_c = crc_q;
			POS_SUM:    byte_c = sum_q;
			default:    byte_c = FIXED_FF;
		endcase
	end

	assign m_axis_tvalid = busy_q;
	assign m_axis_tdata  = {4'b0000, cnt_q, byte_c};
	assign m_axis_tlast  = last_c;

endmodule
